@@ sv/hrhp_pkg.sv @@
// Shared types and codes for the HTTP request header parser.
`default_nettype none

package hrhp_pkg;

   // Parse phase, one-hot
   typedef enum logic [6:0] {
      PH_METHOD = 7'b0000001,
      PH_PATH   = 7'b0000010,
      PH_PROTO  = 7'b0000100,
      PH_NAME   = 7'b0001000,
      PH_SEP    = 7'b0010000,
      PH_VALUE  = 7'b0100000,
      PH_BODY   = 7'b1000000
   } phase_type;

   // Byte classes
   localparam logic [2:0] CLS_DELIM    = 3'd0;
   localparam logic [2:0] CLS_METHOD   = 3'd1;
   localparam logic [2:0] CLS_PATH     = 3'd2;
   localparam logic [2:0] CLS_PROTO    = 3'd3;
   localparam logic [2:0] CLS_HDR_NAME = 3'd4;
   localparam logic [2:0] CLS_HDR_VAL  = 3'd5;
   localparam logic [2:0] CLS_BODY     = 3'd6;

   // Method codes
   localparam logic [2:0] METH_NONE   = 3'd0;
   localparam logic [2:0] METH_GET    = 3'd1;
   localparam logic [2:0] METH_POST   = 3'd2;
   localparam logic [2:0] METH_PUT    = 3'd3;
   localparam logic [2:0] METH_DELETE = 3'd4;

   // Status and error codes
   localparam logic [2:0] ST_PARSING   = 3'd0;
   localparam logic [2:0] ST_LINE_OK   = 3'd1;
   localparam logic [2:0] ST_HDR_DONE  = 3'd2;
   localparam logic [2:0] ST_NUL       = 3'd3;
   localparam logic [2:0] ST_BAD_EOL   = 3'd4;
   localparam logic [2:0] ST_BAD_REQ   = 3'd5;
   localparam logic [2:0] ST_BAD_HDR   = 3'd6;
   localparam logic [2:0] ST_TRUNCATED = 3'd7;

   // Characters
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_COLON = 8'h3A;

   localparam int PROTO_LEN = 8;

   typedef struct packed {
      phase_type  phase;
      logic [2:0] method_pos;
      logic [3:0] method_cand;
      logic [3:0] proto_pos;
      logic       proto_ok;
      logic       sep_seen;
      logic       prev_cr;
      logic       line_empty;
      logic [2:0] method;
      logic [2:0] err;
   } parse_state_type;

   localparam parse_state_type STATE_RESET = '{
      phase:       PH_METHOD,
      method_pos:  3'd0,
      method_cand: 4'hF,
      proto_pos:   4'd0,
      proto_ok:    1'b1,
      sep_seen:    1'b0,
      prev_cr:     1'b0,
      line_empty:  1'b1,
      method:      METH_NONE,
      err:         ST_PARSING
   };

   typedef struct packed {
      logic [7:0] data;
      logic       has_next;
      logic [7:0] next;
      logic       last;
   } classify_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [2:0] byte_class;
      logic [2:0] method_code;
      logic [2:0] parse_status;
      logic       end_of_run;
   } result_type;

endpackage

`default_nettype wire

@@ sv/hrhp_classifier.sv @@
// Per-byte classification and parser state update.
`default_nettype none

module hrhp_classifier (
   input  hrhp_pkg::parse_state_type  state_cur,
   input  hrhp_pkg::classify_req_type creq,
   output hrhp_pkg::parse_state_type  state_nxt,
   output hrhp_pkg::result_type       result
);

   function automatic logic [7:0] meth_char(input logic [1:0] k, input logic [2:0] pos);
      logic [7:0] ch;
      ch = 8'h00;
      case (k)
         2'd0: case (pos)
            3'd0: ch = "G";
            3'd1: ch = "E";
            3'd2: ch = "T";
            default: ch = 8'h00;
         endcase
         2'd1: case (pos)
            3'd0: ch = "P";
            3'd1: ch = "O";
            3'd2: ch = "S";
            3'd3: ch = "T";
            default: ch = 8'h00;
         endcase
         2'd2: case (pos)
            3'd0: ch = "P";
            3'd1: ch = "U";
            3'd2: ch = "T";
            default: ch = 8'h00;
         endcase
         default: case (pos)
            3'd0: ch = "D";
            3'd1: ch = "E";
            3'd2: ch = "L";
            3'd3: ch = "E";
            3'd4: ch = "T";
            3'd5: ch = "E";
            default: ch = 8'h00;
         endcase
      endcase
      return ch;
   endfunction

   function automatic logic [2:0] meth_len(input logic [1:0] k);
      logic [2:0] len;
      case (k)
         2'd0:    len = 3'd3;
         2'd1:    len = 3'd4;
         2'd2:    len = 3'd3;
         default: len = 3'd6;
      endcase
      return len;
   endfunction

   function automatic logic [7:0] proto_char(input logic [2:0] pos);
      logic [7:0] ch;
      case (pos)
         3'd0:    ch = "H";
         3'd1:    ch = "T";
         3'd2:    ch = "T";
         3'd3:    ch = "P";
         3'd4:    ch = "/";
         3'd5:    ch = "1";
         3'd6:    ch = ".";
         default: ch = "1";
      endcase
      return ch;
   endfunction

   hrhp_pkg::parse_state_type n;
   logic [2:0] cls;
   logic [3:0] pick;
   logic [3:0] keep;
   logic       in_req_line;
   logic       c_is_delim;

   always_comb begin
      pick = '0;
      keep = '0;
      for (int k = 0; k < 4; k++) begin
         pick[k] = state_cur.method_cand[k] && (meth_len(2'(k)) == state_cur.method_pos);
         keep[k] = state_cur.method_cand[k] && (state_cur.method_pos < meth_len(2'(k))) &&
                   (meth_char(2'(k), state_cur.method_pos) == creq.data);
      end
   end

   assign in_req_line = (state_cur.phase == hrhp_pkg::PH_METHOD) ||
                        (state_cur.phase == hrhp_pkg::PH_PATH) ||
                        (state_cur.phase == hrhp_pkg::PH_PROTO);
   assign c_is_delim  = (creq.data == hrhp_pkg::CH_CR) || (creq.data == hrhp_pkg::CH_LF);

   always_comb begin
      n   = state_cur;
      cls = hrhp_pkg::CLS_DELIM;
      if (state_cur.err == hrhp_pkg::ST_PARSING) begin
         if (state_cur.phase == hrhp_pkg::PH_BODY) begin
            cls = hrhp_pkg::CLS_BODY;
         end else if (creq.data == hrhp_pkg::CH_NUL) begin
            n.err = hrhp_pkg::ST_NUL;
         end else if (state_cur.prev_cr && creq.data != hrhp_pkg::CH_LF) begin
            n.err = hrhp_pkg::ST_BAD_EOL;
         end else if (creq.data == hrhp_pkg::CH_CR) begin
            n.prev_cr = 1'b1;
         end else if (creq.data == hrhp_pkg::CH_LF) begin
            if (!state_cur.prev_cr) begin
               n.err = hrhp_pkg::ST_BAD_EOL;
            end else begin
               // end of line
               n.prev_cr = 1'b0;
               if (state_cur.line_empty) begin
                  if (in_req_line) n.err = hrhp_pkg::ST_BAD_REQ;
                  else n.phase = hrhp_pkg::PH_BODY;
               end else begin
                  n.line_empty = 1'b1;
                  if (in_req_line) begin
                     if (state_cur.phase == hrhp_pkg::PH_PROTO && state_cur.proto_ok &&
                         state_cur.proto_pos == 4'(hrhp_pkg::PROTO_LEN) &&
                         state_cur.method_cand != 4'h0) begin
                        if (state_cur.method_cand[3])      n.method = hrhp_pkg::METH_DELETE;
                        else if (state_cur.method_cand[2]) n.method = hrhp_pkg::METH_PUT;
                        else if (state_cur.method_cand[1]) n.method = hrhp_pkg::METH_POST;
                        else                               n.method = hrhp_pkg::METH_GET;
                        n.phase = hrhp_pkg::PH_NAME;
                     end else begin
                        n.err = hrhp_pkg::ST_BAD_REQ;
                     end
                  end else if (state_cur.phase == hrhp_pkg::PH_VALUE && state_cur.sep_seen) begin
                     n.phase    = hrhp_pkg::PH_NAME;
                     n.sep_seen = 1'b0;
                  end else begin
                     n.err = hrhp_pkg::ST_BAD_HDR;
                  end
               end
            end
         end else if (!c_is_delim) begin
            n.line_empty = 1'b0;
            unique case (state_cur.phase)
               hrhp_pkg::PH_METHOD: begin
                  if (creq.data == hrhp_pkg::CH_SP) begin
                     n.method_cand = pick;
                     n.phase       = hrhp_pkg::PH_PATH;
                     if (pick == 4'h0) n.err = hrhp_pkg::ST_BAD_REQ;
                  end else begin
                     n.method_cand = keep;
                     if (state_cur.method_pos != 3'd7) n.method_pos = state_cur.method_pos + 3'd1;
                     cls = hrhp_pkg::CLS_METHOD;
                  end
               end
               hrhp_pkg::PH_PATH: begin
                  if (creq.data == hrhp_pkg::CH_SP) n.phase = hrhp_pkg::PH_PROTO;
                  else cls = hrhp_pkg::CLS_PATH;
               end
               hrhp_pkg::PH_PROTO: begin
                  if (creq.data == hrhp_pkg::CH_SP) begin
                     n.err = hrhp_pkg::ST_BAD_REQ;  // third space
                  end else begin
                     if (state_cur.proto_pos >= 4'(hrhp_pkg::PROTO_LEN) ||
                         proto_char(state_cur.proto_pos[2:0]) != creq.data)
                        n.proto_ok = 1'b0;
                     if (state_cur.proto_pos != 4'd15) n.proto_pos = state_cur.proto_pos + 4'd1;
                     cls = hrhp_pkg::CLS_PROTO;
                  end
               end
               hrhp_pkg::PH_NAME: begin
                  // colon counts as separator only with a space behind it on a non-empty name
                  if (creq.data == hrhp_pkg::CH_COLON && creq.has_next &&
                      creq.next == hrhp_pkg::CH_SP && !state_cur.line_empty) begin
                     n.sep_seen = 1'b1;
                     n.phase    = hrhp_pkg::PH_SEP;
                  end else begin
                     cls = hrhp_pkg::CLS_HDR_NAME;
                  end
               end
               hrhp_pkg::PH_SEP: n.phase = hrhp_pkg::PH_VALUE;
               default: cls = hrhp_pkg::CLS_HDR_VAL;
            endcase
         end
         if (n.err != hrhp_pkg::ST_PARSING) cls = hrhp_pkg::CLS_DELIM;
      end
      if (creq.last && n.err == hrhp_pkg::ST_PARSING && n.phase != hrhp_pkg::PH_BODY)
         n.err = hrhp_pkg::ST_TRUNCATED;
   end

   assign state_nxt = n;

   always_comb begin
      result.out_byte    = creq.data;
      result.byte_class  = cls;
      result.method_code = n.method;
      result.end_of_run  = creq.last;
      if (n.err != hrhp_pkg::ST_PARSING)
         result.parse_status = n.err;
      else if (n.phase == hrhp_pkg::PH_METHOD || n.phase == hrhp_pkg::PH_PATH ||
               n.phase == hrhp_pkg::PH_PROTO)
         result.parse_status = hrhp_pkg::ST_PARSING;
      else if (n.phase == hrhp_pkg::PH_BODY)
         result.parse_status = hrhp_pkg::ST_HDR_DONE;
      else
         result.parse_status = hrhp_pkg::ST_LINE_OK;
   end

endmodule

`default_nettype wire

@@ sv/http_request_header_parser_unit.sv @@
// Top level of the HTTP request header parser: request register, byte hold and result register.
//
// Takes one request byte per cycle while the result side does not stall and no final byte is
// pending, and returns its class one byte late, since a colon is a header separator only when a
// space follows it. A byte that is not marked final yields the result of the byte before it (none
// for the first byte of a request). The final byte yields the result of the held byte and then
// its own, marked end_of_run, after which the parser returns to its reset state. The rate is set
// by the single result register, which takes one result a cycle; a stall on the result side
// leaves room for one more request in the input register.
`default_nettype none

module http_request_header_parser_unit (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_is_final,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_byte,
   output logic [2:0]      rsp_byte_class,
   output logic [2:0]      rsp_method_code,
   output logic [2:0]      rsp_parse_status,
   output logic            rsp_end_of_run
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_final_ff;
   logic [7:0] held_byte_ff;
   logic       held_valid_ff, held_valid_in;
   logic       fin_pend_ff, fin_pend_in;
   logic       rsp_valid_ff, rsp_valid_in;

   hrhp_pkg::parse_state_type  state_ff, state_in, state_nxt;
   hrhp_pkg::classify_req_type creq;
   hrhp_pkg::result_type       result, rsp_ff;

   logic out_free;
   logic consume;
   logic do_classify;

   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign consume     = in_valid_ff && !fin_pend_ff && (!held_valid_ff || out_free);
   assign do_classify = fin_pend_ff ? out_free : (consume && held_valid_ff);
   assign req_ready   = !in_valid_ff || consume;

   assign creq.data     = held_byte_ff;
   assign creq.has_next = !fin_pend_ff;
   assign creq.next     = in_byte_ff;
   assign creq.last     = fin_pend_ff;

   hrhp_classifier u_classifier (
      .state_cur (state_ff),
      .creq      (creq),
      .state_nxt (state_nxt),
      .result    (result)
   );

   always_comb begin
      in_valid_in   = in_valid_ff;
      held_valid_in = held_valid_ff;
      fin_pend_in   = fin_pend_ff;
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      if (consume) in_valid_in = 1'b0;
      if (req_valid && req_ready) in_valid_in = 1'b1;
      if (do_classify) begin
         rsp_valid_in = 1'b1;
         state_in     = state_nxt;
      end
      if (fin_pend_ff && out_free) begin
         // request complete: back to reset state
         fin_pend_in   = 1'b0;
         held_valid_in = 1'b0;
         state_in      = hrhp_pkg::STATE_RESET;
      end
      if (consume) begin
         if (in_final_ff) begin
            fin_pend_in   = 1'b1;
            held_valid_in = 1'b0;
         end else begin
            held_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         held_valid_ff <= 1'b0;
         fin_pend_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         state_ff      <= hrhp_pkg::STATE_RESET;
      end else begin
         in_valid_ff   <= in_valid_in;
         held_valid_ff <= held_valid_in;
         fin_pend_ff   <= fin_pend_in;
         rsp_valid_ff  <= rsp_valid_in;
         state_ff      <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff  <= req_data_byte;
         in_final_ff <= req_is_final;
      end
      if (consume) held_byte_ff <= in_byte_ff;
      if (do_classify) rsp_ff <= result;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_byte     = rsp_ff.out_byte;
   assign rsp_byte_class   = rsp_ff.byte_class;
   assign rsp_method_code  = rsp_ff.method_code;
   assign rsp_parse_status = rsp_ff.parse_status;
   assign rsp_end_of_run   = rsp_ff.end_of_run;

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// Testbench for the HTTP request header parser: directed requests, then random request streams.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT   = 5000;
   localparam int BYTES_PER_RUN = 240;

   typedef struct {
      string      text;
      int         nul_at;   // index replaced by NUL, negative for none
      bit         pinned;   // final tag typed in below rather than predicted
      logic [2:0] cls;
      logic [2:0] meth;
      logic [2:0] status;
   } case_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_is_final = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_byte;
   logic [2:0] rsp_byte_class;
   logic [2:0] rsp_method_code;
   logic [2:0] rsp_parse_status;
   logic       rsp_end_of_run;

   int send_idle_pct = 19;
   int recv_idle_pct = 55;
   int mismatches = 0;
   int bytes_sent = 0;
   int stalled = 0;

   // parser model state
   hrhp_pkg::parse_state_type ps;
   logic [7:0]                held_byte;
   bit                        held_valid;

   hrhp_pkg::result_type byte_tags[$];
   hrhp_pkg::result_type want;
   hrhp_pkg::result_type pinned_tag;
   logic [7:0]           byte_buf[$];
   case_row_type         directed_cases[$];

   string      method_names[4] = '{"GET", "POST", "PUT", "DELETE"};
   logic [2:0] method_codes[4] = '{hrhp_pkg::METH_GET, hrhp_pkg::METH_POST,
                                   hrhp_pkg::METH_PUT, hrhp_pkg::METH_DELETE};
   string      proto_text = "HTTP/1.1";
   logic [7:0] special_chars[5] = '{hrhp_pkg::CH_NUL, hrhp_pkg::CH_CR, hrhp_pkg::CH_LF,
                                    hrhp_pkg::CH_SP, hrhp_pkg::CH_COLON};

   http_request_header_parser_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_is_final     (req_is_final),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_byte_class   (rsp_byte_class),
      .rsp_method_code  (rsp_method_code),
      .rsp_parse_status (rsp_parse_status),
      .rsp_end_of_run   (rsp_end_of_run)
   );

   always #5ns clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   function automatic void clear_parser();
      ps.phase       = hrhp_pkg::PH_METHOD;
      ps.method_pos  = 3'd0;
      ps.method_cand = 4'hF;
      ps.proto_pos   = 4'd0;
      ps.proto_ok    = 1'b1;
      ps.sep_seen    = 1'b0;
      ps.prev_cr     = 1'b0;
      ps.line_empty  = 1'b1;
      ps.method      = hrhp_pkg::METH_NONE;
      ps.err         = hrhp_pkg::ST_PARSING;
      held_byte      = 8'h00;
      held_valid     = 1'b0;
   endfunction

   function automatic bit on_request_line();
      return ps.phase == hrhp_pkg::PH_METHOD || ps.phase == hrhp_pkg::PH_PATH ||
             ps.phase == hrhp_pkg::PH_PROTO;
   endfunction

   // Tags one byte; nxt is the byte after it, needed to spot a colon-space.
   function automatic hrhp_pkg::result_type tag_byte(logic [7:0] c, bit has_next,
                                                     logic [7:0] nxt, bit last);
      hrhp_pkg::result_type r;
      logic [2:0] cls;
      logic [3:0] cand;
      bit         was_empty;
      int         k;
      cls = hrhp_pkg::CLS_DELIM;
      if (ps.err == hrhp_pkg::ST_PARSING) begin
         if (ps.phase == hrhp_pkg::PH_BODY) begin
            cls = hrhp_pkg::CLS_BODY;
         end else if (c == hrhp_pkg::CH_NUL) begin
            ps.err = hrhp_pkg::ST_NUL;
         end else if (ps.prev_cr && c != hrhp_pkg::CH_LF) begin
            ps.err = hrhp_pkg::ST_BAD_EOL;
         end else if (c == hrhp_pkg::CH_CR) begin
            ps.prev_cr = 1'b1;
         end else if (c == hrhp_pkg::CH_LF) begin
            if (!ps.prev_cr) begin
               ps.err = hrhp_pkg::ST_BAD_EOL;
            end else begin
               ps.prev_cr = 1'b0;
               if (ps.line_empty) begin
                  // blank line ends the header, but is fatal as the request line
                  if (on_request_line()) ps.err = hrhp_pkg::ST_BAD_REQ;
                  else ps.phase = hrhp_pkg::PH_BODY;
               end else begin
                  if (ps.phase == hrhp_pkg::PH_PROTO && ps.proto_ok &&
                      ps.proto_pos == 4'(hrhp_pkg::PROTO_LEN) && ps.method_cand != 4'd0) begin
                     for (k = 0; k < 4; k++)
                        if (ps.method_cand[k]) ps.method = method_codes[k];
                     ps.phase = hrhp_pkg::PH_NAME;
                  end else if (on_request_line()) begin
                     ps.err = hrhp_pkg::ST_BAD_REQ;
                  end else if (ps.phase == hrhp_pkg::PH_VALUE && ps.sep_seen) begin
                     ps.phase    = hrhp_pkg::PH_NAME;
                     ps.sep_seen = 1'b0;
                  end else begin
                     ps.err = hrhp_pkg::ST_BAD_HDR;
                  end
                  ps.line_empty = 1'b1;
               end
            end
         end else begin
            was_empty     = ps.line_empty;
            ps.line_empty = 1'b0;
            cand          = 4'd0;
            case (ps.phase)
               hrhp_pkg::PH_METHOD: begin
                  if (c == hrhp_pkg::CH_SP) begin
                     for (k = 0; k < 4; k++)
                        if (ps.method_cand[k] && method_names[k].len() == ps.method_pos)
                           cand[k] = 1'b1;
                     ps.method_cand = cand;
                     ps.phase       = hrhp_pkg::PH_PATH;
                     if (cand == 4'd0) ps.err = hrhp_pkg::ST_BAD_REQ;
                  end else begin
                     for (k = 0; k < 4; k++)
                        if (ps.method_cand[k] && ps.method_pos < method_names[k].len()
                            && method_names[k][ps.method_pos] == c)
                           cand[k] = 1'b1;
                     ps.method_cand = cand;
                     if (ps.method_pos != 3'd7) ps.method_pos = ps.method_pos + 3'd1;
                     cls = hrhp_pkg::CLS_METHOD;
                  end
               end
               hrhp_pkg::PH_PATH: begin
                  if (c == hrhp_pkg::CH_SP) ps.phase = hrhp_pkg::PH_PROTO;
                  else cls = hrhp_pkg::CLS_PATH;
               end
               hrhp_pkg::PH_PROTO: begin
                  if (c == hrhp_pkg::CH_SP) begin
                     ps.err = hrhp_pkg::ST_BAD_REQ;
                  end else begin
                     if (ps.proto_pos >= 4'(hrhp_pkg::PROTO_LEN) ||
                         proto_text[ps.proto_pos] != c)
                        ps.proto_ok = 1'b0;
                     if (ps.proto_pos != 4'd15) ps.proto_pos = ps.proto_pos + 4'd1;
                     cls = hrhp_pkg::CLS_PROTO;
                  end
               end
               hrhp_pkg::PH_NAME: begin
                  if (c == hrhp_pkg::CH_COLON && has_next && nxt == hrhp_pkg::CH_SP &&
                      !was_empty) begin
                     ps.sep_seen = 1'b1;
                     ps.phase    = hrhp_pkg::PH_SEP;
                  end else begin
                     cls = hrhp_pkg::CLS_HDR_NAME;
                  end
               end
               hrhp_pkg::PH_SEP: ps.phase = hrhp_pkg::PH_VALUE;
               default: cls = hrhp_pkg::CLS_HDR_VAL;
            endcase
         end
         if (ps.err != hrhp_pkg::ST_PARSING) cls = hrhp_pkg::CLS_DELIM;
      end
      if (last && ps.err == hrhp_pkg::ST_PARSING && ps.phase != hrhp_pkg::PH_BODY)
         ps.err = hrhp_pkg::ST_TRUNCATED;
      r.out_byte    = c;
      r.byte_class  = cls;
      r.method_code = ps.method;
      if (ps.err != hrhp_pkg::ST_PARSING) r.parse_status = ps.err;
      else if (on_request_line()) r.parse_status = hrhp_pkg::ST_PARSING;
      else if (ps.phase == hrhp_pkg::PH_BODY) r.parse_status = hrhp_pkg::ST_HDR_DONE;
      else r.parse_status = hrhp_pkg::ST_LINE_OK;
      r.end_of_run = last;
      return r;
   endfunction

   // One accepted request: tags the held byte, and the final byte too when marked.
   function automatic void step_parser(logic [7:0] d, bit fin);
      if (held_valid) byte_tags.push_back(tag_byte(held_byte, 1'b1, d, 1'b0));
      if (fin) begin
         byte_tags.push_back(tag_byte(d, 1'b0, 8'h00, 1'b1));
         clear_parser();
      end else begin
         held_byte  = d;
         held_valid = 1'b1;
      end
   endfunction

   function automatic void check_field(string what, int expected, int actual);
      if (expected != actual) begin
         $display("%0t: %s expected %0d, got %0d", $time, what, expected, actual);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (byte_tags.size() == 0) begin
            $display("%0t: result with none expected, got byte %0d class %0d", $time,
                     rsp_out_byte, rsp_byte_class);
            mismatches++;
         end else begin
            want = byte_tags.pop_front();
            check_field("out_byte", want.out_byte, rsp_out_byte);
            check_field("byte_class", want.byte_class, rsp_byte_class);
            check_field("method_code", want.method_code, rsp_method_code);
            check_field("parse_status", want.parse_status, rsp_parse_status);
            check_field("end_of_run", want.end_of_run, rsp_end_of_run);
         end
      end
   end

   initial begin
      while (stalled < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stalled = 0;
         else stalled++;
      end
      $display("tb: failure");
      $finish;
   end

   task automatic add_case(string text, int nul_at, bit pinned, logic [2:0] cls,
                           logic [2:0] meth, logic [2:0] status);
      case_row_type row;
      row.text   = text;
      row.nul_at = nul_at;
      row.pinned = pinned;
      row.cls    = cls;
      row.meth   = meth;
      row.status = status;
      directed_cases.push_back(row);
   endtask

   task automatic push_text(string s);
      for (int i = 0; i < s.len(); i++) byte_buf.push_back(s[i]);
   endtask

   task automatic push_random(int min_len, int max_len, int lo, int hi);
      int n;
      n = $urandom_range(max_len, min_len);
      repeat (n) byte_buf.push_back(8'($urandom_range(hi, lo)));
   endtask

   task automatic send_byte(logic [7:0] d, bit fin);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= d;
      req_is_final  <= fin;
      do @(posedge clock); while (!req_ready);
      step_parser(d, fin);
      bytes_sent++;
   endtask

   task automatic send_buffer();
      for (int i = 0; i < byte_buf.size(); i++) send_byte(byte_buf[i], i == byte_buf.size() - 1);
   endtask

   // Mostly well-formed requests with random content; some mangled, some pure noise.
   task automatic build_random_request();
      int         kind;
      int         pos;
      logic [7:0] odd_byte;
      byte_buf.delete();
      kind = $urandom_range(99);
      if (kind < 6) begin
         push_random(1, 8, 0, 255);
         return;
      end
      push_text(method_names[$urandom_range(3)]);
      byte_buf.push_back(hrhp_pkg::CH_SP);
      push_random(1, 6, 33, 126);
      byte_buf.push_back(hrhp_pkg::CH_SP);
      push_text(proto_text);
      push_text("\015\012");
      repeat ($urandom_range(2)) begin
         push_random(1, 5, 33, 126);
         push_text(": ");
         push_random(0, 6, 32, 126);
         push_text("\015\012");
      end
      push_text("\015\012");
      push_random(0, 4, 0, 255);
      if (kind >= 70) begin
         pos = $urandom_range(byte_buf.size() - 1);
         odd_byte = $urandom_range(1) ? special_chars[$urandom_range(4)]
                                      : 8'($urandom_range(255));
         case ($urandom_range(3))
            0: byte_buf.insert(pos, odd_byte);
            1: if (byte_buf.size() > 1) byte_buf.delete(pos);
            2: while (byte_buf.size() > pos + 1) void'(byte_buf.pop_back());
            default: byte_buf[pos] = odd_byte;
         endcase
      end
   endtask

   initial begin
      int run_start;
      clear_parser();

      add_case("GET / HTTP/1.1\015\012\015\012", -1, 1,
               hrhp_pkg::CLS_DELIM, hrhp_pkg::METH_GET, hrhp_pkg::ST_HDR_DONE);
      add_case("POST /a HTTP/1.1\015\012Host: x\015\012\015\012body", -1, 1,
               hrhp_pkg::CLS_BODY, hrhp_pkg::METH_POST, hrhp_pkg::ST_HDR_DONE);
      add_case("PUT /p HTTP/1.1\015\012A: b: c\015\012\015\012", -1, 1,
               hrhp_pkg::CLS_DELIM, hrhp_pkg::METH_PUT, hrhp_pkg::ST_HDR_DONE);
      // body may hold CR and NUL
      add_case("DELETE /d HTTP/1.1\015\012K: v\015\012\015\012\015X", 29, 1,
               hrhp_pkg::CLS_BODY, hrhp_pkg::METH_DELETE, hrhp_pkg::ST_HDR_DONE);
      add_case("GET / HTTP/1.1\015\012AX: b\015\012\015\012", 17, 1,
               hrhp_pkg::CLS_DELIM, hrhp_pkg::METH_GET, hrhp_pkg::ST_NUL);
      add_case("X", 0, 1, hrhp_pkg::CLS_DELIM, hrhp_pkg::METH_NONE, hrhp_pkg::ST_NUL);
      add_case("GET / HTTP/1.1\015X", -1, 1,
               hrhp_pkg::CLS_DELIM, hrhp_pkg::METH_NONE, hrhp_pkg::ST_BAD_EOL);
      add_case("GET / HTTP/1.1\012", -1, 1,
               hrhp_pkg::CLS_DELIM, hrhp_pkg::METH_NONE, hrhp_pkg::ST_BAD_EOL);
      add_case("GET / HTTP/1.1\015\012A: b\015c", -1, 1,
               hrhp_pkg::CLS_DELIM, hrhp_pkg::METH_GET, hrhp_pkg::ST_BAD_EOL);
      add_case("\015\012", -1, 1,
               hrhp_pkg::CLS_DELIM, hrhp_pkg::METH_NONE, hrhp_pkg::ST_BAD_REQ);
      add_case("GETX / HTTP/1.1\015\012\015\012", -1, 1,
               hrhp_pkg::CLS_DELIM, hrhp_pkg::METH_NONE, hrhp_pkg::ST_BAD_REQ);
      add_case("DEL / HTTP/1.1\015\012\015\012", -1, 1,
               hrhp_pkg::CLS_DELIM, hrhp_pkg::METH_NONE, hrhp_pkg::ST_BAD_REQ);
      add_case("DELETEDELETE / HTTP/1.1\015\012", -1, 1,
               hrhp_pkg::CLS_DELIM, hrhp_pkg::METH_NONE, hrhp_pkg::ST_BAD_REQ);
      add_case("GET / HTTP/1.1 x\015\012", -1, 1,
               hrhp_pkg::CLS_DELIM, hrhp_pkg::METH_NONE, hrhp_pkg::ST_BAD_REQ);
      add_case("GET / HTTP/1.0\015\012\015\012", -1, 1,
               hrhp_pkg::CLS_DELIM, hrhp_pkg::METH_NONE, hrhp_pkg::ST_BAD_REQ);
      add_case("GET /\015\012", -1, 1,
               hrhp_pkg::CLS_DELIM, hrhp_pkg::METH_NONE, hrhp_pkg::ST_BAD_REQ);
      add_case("GET / HTTP/1.1/extra/long/proto\015\012", -1, 1,
               hrhp_pkg::CLS_DELIM, hrhp_pkg::METH_NONE, hrhp_pkg::ST_BAD_REQ);
      add_case("GET / HTTP/1.1\015\012: v\015\012\015\012", -1, 1,
               hrhp_pkg::CLS_DELIM, hrhp_pkg::METH_GET, hrhp_pkg::ST_BAD_HDR);
      add_case("GET / HTTP/1.1\015\012NoColon\015\012\015\012", -1, 1,
               hrhp_pkg::CLS_DELIM, hrhp_pkg::METH_GET, hrhp_pkg::ST_BAD_HDR);
      add_case("GET / HTTP/1.1\015\012Abc:", -1, 1,
               hrhp_pkg::CLS_HDR_NAME, hrhp_pkg::METH_GET, hrhp_pkg::ST_TRUNCATED);
      add_case("GET / HTTP/1.1\015\012A: b", -1, 1,
               hrhp_pkg::CLS_HDR_VAL, hrhp_pkg::METH_GET, hrhp_pkg::ST_TRUNCATED);
      add_case("GET /x HTTP/1.1\015\012", -1, 1,
               hrhp_pkg::CLS_DELIM, hrhp_pkg::METH_GET, hrhp_pkg::ST_TRUNCATED);
      add_case("\377", -1, 1,
               hrhp_pkg::CLS_METHOD, hrhp_pkg::METH_NONE, hrhp_pkg::ST_TRUNCATED);
      add_case("GET / HTTP/1.1\015\012A:b: c\015\012\015\012", -1, 0, 0, 0, 0);
      add_case("PUT / HTTP/1.1\015\012A: \015\012\015\012~\177", -1, 0, 0, 0, 0);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_cases[i]) begin
         byte_buf.delete();
         push_text(directed_cases[i].text);
         if (directed_cases[i].nul_at >= 0) byte_buf[directed_cases[i].nul_at] = hrhp_pkg::CH_NUL;
         send_buffer();
         if (directed_cases[i].pinned) begin
            pinned_tag.out_byte     = byte_buf[byte_buf.size() - 1];
            pinned_tag.byte_class   = directed_cases[i].cls;
            pinned_tag.method_code  = directed_cases[i].meth;
            pinned_tag.parse_status = directed_cases[i].status;
            pinned_tag.end_of_run   = 1'b1;
            byte_tags[byte_tags.size() - 1] = pinned_tag;
         end
      end

      for (int run = 0; run < 3; run++) begin
         case (run)
            0: begin send_idle_pct = 19; recv_idle_pct = 55; end
            1: begin send_idle_pct = 55; recv_idle_pct = 19; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         run_start = bytes_sent;
         while (bytes_sent - run_start < BYTES_PER_RUN) begin
            build_random_request();
            send_buffer();
         end
      end
      req_valid <= 1'b0;

      while (byte_tags.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule
